FILE: rtl/rins_pkg.sv
// types, constants and helper functions shared by the range image normal block
// no dependencies; compiled before every other file
package rins_pkg;

  localparam int ADDR_W        = 5;
  localparam int CORDIC_STEPS  = 24;
  localparam int DIV_STEPS     = 32;
  localparam int ROOT_STEPS    = 32;
  localparam int READ_STEPS    = 3;
  localparam int CROSS_STEPS   = 6;

  localparam logic [2:0] REG_COLS       = 3'd0;
  localparam logic [2:0] REG_ROWS       = 3'd1;
  localparam logic [2:0] REG_COL_STEP   = 3'd2;
  localparam logic [2:0] REG_LINE_STEP  = 3'd3;
  localparam logic [2:0] REG_SLANT_STEP = 3'd4;
  localparam logic [2:0] REG_STANDOFF   = 3'd5;

  localparam logic signed [26:0] ANGLE_LIMIT = 27'sd25165824;
  localparam logic signed [33:0] CORDIC_X0   = 34'sd1073741824;
  localparam logic signed [44:0] OUT_MAX     = 45'sd1099511627775;
  localparam logic signed [44:0] OUT_MIN     = -45'sd1099511627776;

  typedef struct packed {
    logic [10:0] cols;
    logic [10:0] rows;
    logic [23:0] col_step;
    logic [23:0] line_step;
    logic [15:0] slant_step;
    logic [7:0]  standoff;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG1, ST_ANG2, ST_CINIT, ST_CSTEP, ST_DINIT, ST_DSTEP, ST_DFIN,
    ST_SQ1, ST_SQ2, ST_RSTEP, ST_ZINIT, ST_ZSTEP, ST_ZFIN, ST_MULX, ST_MULY,
    ST_READ, ST_CROSS, ST_WRITE, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ANG1, OP_ANG2, OP_CINIT, OP_CSTEP, OP_DINIT_T, OP_DSTEP,
    OP_DFIN_T, OP_SQ1, OP_SQ2, OP_RSTEP, OP_DINIT_Z, OP_DFIN_Z, OP_MULX, OP_MULY,
    OP_READ, OP_CROSS, OP_WRITE, OP_LDOUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] step;
    logic       sel_y;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
  } dp_sts_t;

  function automatic logic signed [26:0] atan_q24(input logic [4:0] i);
    logic signed [26:0] v;
    case (i)
      5'd0:    v = 27'sd13176795;
      5'd1:    v = 27'sd7778716;
      5'd2:    v = 27'sd4110060;
      5'd3:    v = 27'sd2086331;
      5'd4:    v = 27'sd1047214;
      5'd5:    v = 27'sd524117;
      5'd6:    v = 27'sd262123;
      5'd7:    v = 27'sd131069;
      5'd8:    v = 27'sd65536;
      5'd9:    v = 27'sd32768;
      5'd10:   v = 27'sd16384;
      5'd11:   v = 27'sd8192;
      5'd12:   v = 27'sd4096;
      5'd13:   v = 27'sd2048;
      5'd14:   v = 27'sd1024;
      5'd15:   v = 27'sd512;
      5'd16:   v = 27'sd256;
      5'd17:   v = 27'sd128;
      5'd18:   v = 27'sd64;
      5'd19:   v = 27'sd32;
      5'd20:   v = 27'sd16;
      5'd21:   v = 27'sd8;
      5'd22:   v = 27'sd4;
      5'd23:   v = 27'sd2;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // half of twice the angle, rounded, limited to +-1.5 rad
  function automatic logic signed [26:0] make_angle(input logic signed [43:0] tw);
    logic signed [43:0] h;
    h = (tw + 44'sd1) >>> 1;
    if (h > 44'sd25165824) begin
      return ANGLE_LIMIT;
    end else if (h < -44'sd25165824) begin
      return -ANGLE_LIMIT;
    end
    return h[26:0];
  endfunction

  function automatic logic signed [40:0] sat_out(input logic signed [48:0] v);
    logic signed [44:0] sh;
    sh = v[48:4];
    if (sh > OUT_MAX) begin
      return OUT_MAX[40:0];
    end else if (sh < OUT_MIN) begin
      return OUT_MIN[40:0];
    end
    return sh[40:0];
  endfunction

endpackage

FILE: rtl/rins_if.sv
// stream interfaces for range pixels in and surface normals out
// no dependencies
interface rins_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] range_value;
  logic       frame_start;
  modport source(output valid, range_value, frame_start, input ready);
  modport sink(input valid, range_value, frame_start, output ready);
endinterface

interface rins_out_if;
  logic               valid;
  logic               ready;
  logic signed [40:0] normal_x;
  logic signed [40:0] normal_y;
  logic signed [40:0] normal_z;
  logic [9:0]         normal_row;
  logic [9:0]         normal_col;
  modport source(output valid, normal_x, normal_y, normal_z, normal_row, normal_col,
                 input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, normal_row, normal_col,
               output ready);
endinterface

FILE: rtl/rins_regs.sv
// apb configuration registers of the range image normal block
// depends on rins_pkg
module rins_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rins_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rins_pkg::cfg_t                cfg
);
  import rins_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_COLS:       cfg_nxt.cols       = pwdata[10:0];
        REG_ROWS:       cfg_nxt.rows       = pwdata[10:0];
        REG_COL_STEP:   cfg_nxt.col_step   = pwdata[23:0];
        REG_LINE_STEP:  cfg_nxt.line_step  = pwdata[23:0];
        REG_SLANT_STEP: cfg_nxt.slant_step = pwdata[15:0];
        REG_STANDOFF:   cfg_nxt.standoff   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COLS:       prdata = {21'd0, cfg_r.cols};
      REG_ROWS:       prdata = {21'd0, cfg_r.rows};
      REG_COL_STEP:   prdata = {8'd0, cfg_r.col_step};
      REG_LINE_STEP:  prdata = {8'd0, cfg_r.line_step};
      REG_SLANT_STEP: prdata = {16'd0, cfg_r.slant_step};
      REG_STANDOFF:   prdata = {24'd0, cfg_r.standoff};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols       <= 11'd128;
      cfg_r.rows       <= 11'd128;
      cfg_r.col_step   <= 24'd137258;
      cfg_r.line_step  <= 24'd137169;
      cfg_r.slant_step <= 16'd715;
      cfg_r.standoff   <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/rins_ctrl.sv
// sequencer of the range image normal block: steps the datapath through one pixel
// depends on rins_pkg
module rins_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rins_pkg::dp_sts_t sts,
  output rins_pkg::dp_cmd_t cmd
);
  import rins_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic       sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 6'd0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sel_nxt   = sel_r;
    load_out  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.step  = step_r;
    cmd.sel_y = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_ANG1;
        end
      end
      ST_ANG1: begin
        cmd.op    = OP_ANG1;
        state_nxt = ST_ANG2;
      end
      ST_ANG2: begin
        cmd.op    = OP_ANG2;
        sel_nxt   = 1'b0;
        state_nxt = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.op    = OP_CINIT;
        step_nxt  = 6'd0;
        state_nxt = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.op = OP_CSTEP;
        if (step_r == 6'(CORDIC_STEPS - 1)) begin
          step_nxt  = 6'd0;
          state_nxt = ST_DINIT;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_DINIT: begin
        cmd.op    = OP_DINIT_T;
        state_nxt = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (step_r == 6'(DIV_STEPS - 1)) begin
          step_nxt  = 6'd0;
          state_nxt = ST_DFIN;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_DFIN: begin
        cmd.op = OP_DFIN_T;
        if (sel_r) begin
          sel_nxt   = 1'b0;
          state_nxt = ST_SQ1;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = ST_CINIT;
        end
      end
      ST_SQ1: begin
        cmd.op    = OP_SQ1;
        sel_nxt   = 1'b1;
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.op    = OP_SQ2;
        step_nxt  = 6'd0;
        state_nxt = ST_RSTEP;
      end
      ST_RSTEP: begin
        cmd.op = OP_RSTEP;
        if (step_r == 6'(ROOT_STEPS - 1)) begin
          step_nxt  = 6'd0;
          state_nxt = ST_ZINIT;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_ZINIT: begin
        cmd.op    = OP_DINIT_Z;
        state_nxt = ST_ZSTEP;
      end
      ST_ZSTEP: begin
        cmd.op = OP_DSTEP;
        if (step_r == 6'(DIV_STEPS - 1)) begin
          step_nxt  = 6'd0;
          state_nxt = ST_ZFIN;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_ZFIN: begin
        cmd.op    = OP_DFIN_Z;
        state_nxt = ST_MULX;
      end
      ST_MULX: begin
        cmd.op    = OP_MULX;
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        cmd.op    = OP_MULY;
        step_nxt  = 6'd0;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.op = OP_READ;
        if (step_r == 6'(READ_STEPS - 1)) begin
          step_nxt  = 6'd0;
          state_nxt = ST_CROSS;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_CROSS: begin
        cmd.op = OP_CROSS;
        if (step_r == 6'(CROSS_STEPS - 1)) begin
          step_nxt  = 6'd0;
          state_nxt = ST_WRITE;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_WRITE: begin
        cmd.op    = OP_WRITE;
        state_nxt = sts.emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op    = OP_LDOUT;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

endmodule

FILE: rtl/rins_dp.sv
// datapath: angles, shared cordic, divider and root units, point rows, cross product
// depends on rins_pkg
module rins_dp #(
  parameter int MAX_COLS        = 1024,
  parameter int MAX_ROWS        = 1024,
  parameter int NEIGHBOR_OFFSET = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rins_pkg::cfg_t        cfg,
  input  rins_pkg::dp_cmd_t     cmd,
  output rins_pkg::dp_sts_t     sts,
  input  logic [7:0]            range_value,
  input  logic                  frame_start,
  output logic signed [40:0]    normal_x,
  output logic signed [40:0]    normal_y,
  output logic signed [40:0]    normal_z,
  output logic [9:0]            normal_row,
  output logic [9:0]            normal_col
);
  import rins_pkg::*;

  localparam int ROW_SLOTS = NEIGHBOR_OFFSET + 1;
  localparam int DEPTH     = ROW_SLOTS * MAX_COLS;
  localparam int AW        = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(MAX_COLS + 1);
  localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
  localparam int CC_W      = $clog2(MAX_COLS);
  localparam int RC_W      = $clog2(MAX_ROWS);
  localparam int SLW       = $clog2(ROW_SLOTS);

  function automatic logic [SLW-1:0] inc_slot(input logic [SLW-1:0] s);
    return (s == SLW'(ROW_SLOTS - 1)) ? '0 : s + SLW'(1);
  endfunction

  // sizes in use
  logic [CNT_W-1:0]  cols_e;
  logic [RCNT_W-1:0] rows_e;

  always_comb begin
    if (cfg.cols == 11'd0) begin
      cols_e = CNT_W'(1);
    end else if (32'(cfg.cols) > MAX_COLS) begin
      cols_e = CNT_W'(MAX_COLS);
    end else begin
      cols_e = CNT_W'(cfg.cols);
    end
    if (cfg.rows == 11'd0) begin
      rows_e = RCNT_W'(1);
    end else if (32'(cfg.rows) > MAX_ROWS) begin
      rows_e = RCNT_W'(MAX_ROWS);
    end else begin
      rows_e = RCNT_W'(cfg.rows);
    end
  end

  // position state
  logic [CC_W-1:0] col_pos_r, col_pos_nxt;
  logic [RC_W-1:0] row_pos_r, row_pos_nxt;
  logic [SLW-1:0]  slot_pos_r, slot_pos_nxt;

  // current pixel
  logic [CC_W-1:0]    c_r;
  logic [RC_W-1:0]    r_r;
  logic [SLW-1:0]     slot_r;
  logic [8:0]         d_r;
  logic               emit_r;
  logic signed [15:0] dc2_r, dr2_r;

  // arithmetic registers
  logic signed [26:0] xa_r, ya_r;
  logic signed [32:0] slp_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [26:0] cz_r;
  logic signed [31:0] tx_r, ty_r;
  logic [34:0]        rem_r;
  logic [31:0]        dlo_r;
  logic [33:0]        dvs_r;
  logic [31:0]        quo_r;
  logic               neg_r;
  logic [63:0]        sq_r, s_r, root_r;
  logic [22:0]        zq_r;
  logic [22:0]        xq_r, yq_r;
  logic [68:0]        pa_r, ph_r, mem_q_r;
  logic signed [47:0] prod_r;
  logic signed [40:0] nx_r, ny_r, nz_r;

  logic [68:0] mem [DEPTH];

  // pre-step position chain
  logic [CC_W-1:0]  c0, c2;
  logic [RC_W-1:0]  r0, r2;
  logic [RC_W:0]    r1;
  logic [SLW-1:0]   s0, s1, s2;
  logic             wrap_c;
  int               dc2_i, dr2_i;

  always_comb begin
    if (frame_start) begin
      c0 = '0;
      r0 = '0;
      s0 = '0;
    end else begin
      c0 = col_pos_r;
      r0 = row_pos_r;
      s0 = slot_pos_r;
    end
    wrap_c = 32'(c0) >= 32'(cols_e);
    if (wrap_c) begin
      c2 = '0;
      r1 = {1'b0, r0} + (RC_W + 1)'(1);
      s1 = inc_slot(s0);
    end else begin
      c2 = c0;
      r1 = {1'b0, r0};
      s1 = s0;
    end
    if (32'(r1) >= 32'(rows_e)) begin
      r2 = '0;
      s2 = '0;
    end else begin
      r2 = r1[RC_W-1:0];
      s2 = s1;
    end
    dc2_i = 2 * int'(c2) - 2 * int'(cols_e >> 1) + 1;
    dr2_i = 2 * int'(rows_e >> 1) - 1 - 2 * int'(r2);
  end

  // angle products
  logic signed [40:0] mx;
  logic signed [41:0] my;
  assign mx = $signed({1'b0, cfg.col_step}) * dc2_r;
  assign my = $signed({1'b0, cfg.line_step}) * dr2_r + 42'(slp_r);

  // cordic step
  logic signed [33:0] xs, ys;
  logic signed [26:0] at;
  assign xs = cx_r >>> cmd.step[4:0];
  assign ys = cy_r >>> cmd.step[4:0];
  assign at = atan_q24(cmd.step[4:0]);

  // divider step
  logic [34:0] tr;
  logic        ge;
  assign tr = {rem_r[33:0], dlo_r[31]};
  assign ge = tr >= {1'b0, dvs_r};

  // root step
  logic [63:0] rbit, rsum;
  assign rbit = 64'd1 << (7'd62 - {cmd.step, 1'b0});
  assign rsum = root_r + rbit;

  logic [33:0]        magy;
  logic signed [63:0] sqt;
  logic signed [55:0] pxz;
  assign magy = cy_r[33] ? 34'(-cy_r) : cy_r;
  assign sqt  = (cmd.sel_y ? ty_r : tx_r) * (cmd.sel_y ? ty_r : tx_r);
  assign pxz  = (cmd.op == OP_MULY ? ty_r : tx_r) * $signed({1'b0, zq_r});

  // addresses
  logic [SLW-1:0] slot_a;
  logic [AW-1:0]  addr_a, addr_h, addr_c;
  assign slot_a = inc_slot(slot_r);
  assign addr_a = AW'(int'(slot_a) * MAX_COLS + int'(c_r));
  assign addr_h = AW'(int'(slot_a) * MAX_COLS + int'(c_r) + NEIGHBOR_OFFSET);
  assign addr_c = AW'(int'(slot_r) * MAX_COLS + int'(c_r));

  // cross product operands
  logic signed [23:0] x1, y1, z1, x2, y2, z2;
  logic signed [23:0] ma, mb;
  logic signed [47:0] mp;
  logic signed [48:0] mdiff;

  always_comb begin
    x1 = {ph_r[68], ph_r[68:46]} - {pa_r[68], pa_r[68:46]};
    y1 = {ph_r[45], ph_r[45:23]} - {pa_r[45], pa_r[45:23]};
    z1 = {ph_r[22], ph_r[22:0]} - {pa_r[22], pa_r[22:0]};
    x2 = {xq_r[22], xq_r} - {pa_r[68], pa_r[68:46]};
    y2 = {yq_r[22], yq_r} - {pa_r[45], pa_r[45:23]};
    z2 = {zq_r[22], zq_r} - {pa_r[22], pa_r[22:0]};
    case (cmd.step[2:0])
      3'd0:    begin ma = y1; mb = z2; end
      3'd1:    begin ma = z1; mb = y2; end
      3'd2:    begin ma = z1; mb = x2; end
      3'd3:    begin ma = x1; mb = z2; end
      3'd4:    begin ma = x1; mb = y2; end
      default: begin ma = y1; mb = x2; end
    endcase
    mp    = ma * mb;
    mdiff = 49'(prod_r) - 49'(mp);
  end

  // position advance after the pixel
  logic [31:0] c1n, r1n;
  always_comb begin
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    slot_pos_nxt = slot_pos_r;
    c1n          = 32'(c_r) + 32'd1;
    r1n          = 32'(r_r) + 32'd1;
    if (cmd.op == OP_WRITE) begin
      if (c1n >= 32'(cols_e)) begin
        col_pos_nxt = '0;
        if (r1n >= 32'(rows_e)) begin
          row_pos_nxt  = '0;
          slot_pos_nxt = '0;
        end else begin
          row_pos_nxt  = RC_W'(r1n);
          slot_pos_nxt = inc_slot(slot_r);
        end
      end else begin
        col_pos_nxt  = CC_W'(c1n);
        row_pos_nxt  = r_r;
        slot_pos_nxt = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      slot_pos_r <= '0;
    end else begin
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      slot_pos_r <= slot_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ) begin
      mem_q_r <= mem[(cmd.step == 6'd0) ? addr_a : addr_h];
    end
    if (cmd.op == OP_WRITE) begin
      mem[addr_c] <= {xq_r, yq_r, zq_r};
    end
  end

  logic [31:0] row_o;
  assign row_o = 32'(r_r) - 32'(NEIGHBOR_OFFSET);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        c_r    <= c2;
        r_r    <= r2;
        slot_r <= s2;
        d_r    <= {1'b0, range_value} + {1'b0, cfg.standoff};
        emit_r <= (32'(r2) >= 32'(NEIGHBOR_OFFSET))
                  && (32'(c2) + 32'(NEIGHBOR_OFFSET) < 32'(cols_e));
        dc2_r  <= 16'(dc2_i);
        dr2_r  <= 16'(dr2_i);
      end
      OP_ANG1: begin
        xa_r  <= make_angle(44'(mx));
        slp_r <= $signed({1'b0, cfg.slant_step}) * dc2_r;
      end
      OP_ANG2: ya_r <= make_angle(44'(my));
      OP_CINIT: begin
        cx_r <= CORDIC_X0;
        cy_r <= '0;
        cz_r <= cmd.sel_y ? ya_r : xa_r;
      end
      OP_CSTEP: begin
        if (!cz_r[26]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      OP_DINIT_T: begin
        rem_r <= {11'd0, magy[31:8]};
        dlo_r <= {magy[7:0], 24'd0};
        dvs_r <= cx_r;
        quo_r <= '0;
        neg_r <= cy_r[33];
      end
      OP_DINIT_Z: begin
        rem_r <= {22'd0, d_r, 4'd0};
        dlo_r <= '0;
        dvs_r <= root_r[33:0];
        quo_r <= '0;
      end
      OP_DSTEP: begin
        rem_r <= ge ? (tr - {1'b0, dvs_r}) : tr;
        quo_r <= {quo_r[30:0], ge};
        dlo_r <= {dlo_r[30:0], 1'b0};
      end
      OP_DFIN_T: begin
        if (cmd.sel_y) begin
          ty_r <= neg_r ? -$signed(quo_r) : $signed(quo_r);
        end else begin
          tx_r <= neg_r ? -$signed(quo_r) : $signed(quo_r);
        end
      end
      OP_SQ1: sq_r <= $unsigned(sqt);
      OP_SQ2: begin
        s_r    <= (64'd1 << 48) + sq_r + $unsigned(sqt);
        root_r <= '0;
      end
      OP_RSTEP: begin
        if (s_r >= rsum) begin
          s_r    <= s_r - rsum;
          root_r <= (root_r >> 1) + rbit;
        end else begin
          root_r <= root_r >> 1;
        end
      end
      OP_DFIN_Z: zq_r <= quo_r[22:0];
      OP_MULX:   xq_r <= pxz[46:24];
      OP_MULY:   yq_r <= pxz[46:24];
      OP_READ: begin
        if (cmd.step == 6'd1) begin
          pa_r <= mem_q_r;
        end else if (cmd.step == 6'd2) begin
          ph_r <= mem_q_r;
        end
      end
      OP_CROSS: begin
        case (cmd.step[2:0])
          3'd0, 3'd2, 3'd4: prod_r <= mp;
          3'd1:             nx_r   <= sat_out(mdiff);
          3'd3:             ny_r   <= sat_out(mdiff);
          default:          nz_r   <= sat_out(mdiff);
        endcase
      end
      OP_LDOUT: begin
        normal_x   <= nx_r;
        normal_y   <= ny_r;
        normal_z   <= nz_r;
        normal_row <= row_o[9:0];
        normal_col <= 10'(c_r);
      end
      default: ;
    endcase
  end

  assign sts.emit = emit_r;

endmodule

FILE: rtl/range_image_surface_normal.sv
// range image to surface normal block: one pixel at a time through a sequencer
// intake is held while the pixel passes the serial cordic (24 steps per angle),
// the shared divider (32 steps, three uses), the root unit (32 steps) and, when
// a normal is made, the emit state; a waiting normal stalls intake only when the
// next normal is ready before it is taken
// synchronous active-low reset clears position, sequencer and output valid;
// the point rows hold no reset and need no clearing pass
module range_image_surface_normal #(
  parameter int MAX_COLS        = 1024,
  parameter int MAX_ROWS        = 1024,
  parameter int NEIGHBOR_OFFSET = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rins_in_if.sink                     in_bus,
  rins_out_if.source                  out_bus,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rins_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rins_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  rins_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rins_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rins_dp #(
    .MAX_COLS        (MAX_COLS),
    .MAX_ROWS        (MAX_ROWS),
    .NEIGHBOR_OFFSET (NEIGHBOR_OFFSET)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .range_value (in_bus.range_value),
    .frame_start (in_bus.frame_start),
    .normal_x    (out_bus.normal_x),
    .normal_y    (out_bus.normal_y),
    .normal_z    (out_bus.normal_z),
    .normal_row  (out_bus.normal_row),
    .normal_col  (out_bus.normal_col)
  );

endmodule

FILE: dv/tb_range_image_surface_normal.sv
`timescale 1ns / 100ps
// testbench for range_image_surface_normal: random range pixels over many image settings
// checks every normal against an in-bench predictor; needs rins_pkg and rins_if
module tb_range_image_surface_normal;
  import rins_pkg::*;

  localparam int OFFSET    = 3;
  localparam int SLOTS     = OFFSET + 1;
  localparam int COLS_MAX  = 1024;
  localparam int ROWS_MAX  = 1024;
  localparam int IDLE_WAIT = 300;
  localparam int WDOG_MAX  = 20000;

  typedef struct {
    logic [7:0] range_value;
    logic       frame_start;
  } pixel_t;

  typedef struct {
    logic [40:0] nx;
    logic [40:0] ny;
    logic [40:0] nz;
    logic [9:0]  row;
    logic [9:0]  col;
  } normal_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_fire;

  rins_in_if  in_bus();
  rins_out_if out_bus();

  range_image_surface_normal u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cfg_t    img_cfg;
  pixel_t  pixel_q[$];
  normal_t normal_q[$];
  int      pt_x[SLOTS*COLS_MAX];
  int      pt_y[SLOTS*COLS_MAX];
  int      pt_z[SLOTS*COLS_MAX];
  int      cur_row, cur_col;
  int      errors, pixels_in, normals_out, phases;
  int      burst_left, gap_left, hold_left, stall_mode, mode_timer, idle_cycles;
  bit      hold_done;
  longint  atan_lut[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint beam_angle(longint twice);
    longint h;
    h = (twice + 1) >>> 1;
    if (h > 25165824) h = 25165824;
    if (h < -25165824) h = -25165824;
    return h;
  endfunction

  function automatic longint tan_of(longint angle);
    longint x, y, z, xs, ys, mag;
    x = longint'(1) << 30;
    y = 0;
    z = angle;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_lut[i];
      end else begin
        x += ys; y -= xs; z += atan_lut[i];
      end
    end
    if (x <= 0) return (y >= 0) ? (longint'(1) << 40) : -(longint'(1) << 40);
    mag = ((y < 0) ? -y : y) << 24;
    mag = mag / x;
    return (y < 0) ? -mag : mag;
  endfunction

  function automatic bit [63:0] root_of(bit [63:0] s);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [40:0] to_q20(longint v);
    longint h;
    h = v >>> 4;
    if (h > 64'sd1099511627775) h = 64'sd1099511627775;
    if (h < -64'sd1099511627776) h = -64'sd1099511627776;
    return h[40:0];
  endfunction

  task automatic predict_normal(pixel_t px);
    int cols, rows, r, c, cur, base, a, h;
    longint dc2, dr2, tx, ty, d, zq, xq, yq, x1, y1, z1, x2, y2, z2;
    bit [63:0] s, q;
    normal_t n;
    cols = img_cfg.cols;
    rows = img_cfg.rows;
    if (cols < 1) cols = 1;
    if (cols > COLS_MAX) cols = COLS_MAX;
    if (rows < 1) rows = 1;
    if (rows > ROWS_MAX) rows = ROWS_MAX;
    if (px.frame_start) begin
      cur_row = 0;
      cur_col = 0;
    end
    if (cur_col >= cols) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= rows) cur_row = 0;
    r = cur_row;
    c = cur_col;
    dc2 = 2 * c - 2 * (cols / 2) + 1;
    dr2 = 2 * (rows / 2) - 1 - 2 * r;
    tx = tan_of(beam_angle(longint'(img_cfg.col_step) * dc2));
    ty = tan_of(beam_angle(longint'(img_cfg.line_step) * dr2
                           + longint'(img_cfg.slant_step) * dc2));
    s = (64'd1 << 48) + 64'(tx * tx) + 64'(ty * ty);
    q = root_of(s);
    if (q == 0) q = 1;
    d = longint'(px.range_value) + longint'(img_cfg.standoff);
    zq = longint'((64'(d) << 36) / q);
    xq = (tx * zq) >>> 24;
    yq = (ty * zq) >>> 24;
    cur = (r % SLOTS) * COLS_MAX + c;
    pt_x[cur] = int'(xq);
    pt_y[cur] = int'(yq);
    pt_z[cur] = int'(zq);
    if (r >= OFFSET && c + OFFSET < cols) begin
      base = ((r - OFFSET) % SLOTS) * COLS_MAX;
      a = base + c;
      h = base + c + OFFSET;
      x1 = longint'(pt_x[h]) - pt_x[a];
      y1 = longint'(pt_y[h]) - pt_y[a];
      z1 = longint'(pt_z[h]) - pt_z[a];
      x2 = longint'(pt_x[cur]) - pt_x[a];
      y2 = longint'(pt_y[cur]) - pt_y[a];
      z2 = longint'(pt_z[cur]) - pt_z[a];
      n.nx = to_q20(y1 * z2 - z1 * y2);
      n.ny = to_q20(z1 * x2 - x1 * z2);
      n.nz = to_q20(x1 * y2 - y1 * x2);
      n.row = 10'(r - OFFSET);
      n.col = 10'(c);
      normal_q.push_back(n);
    end
    cur_col = c + 1;
    if (cur_col >= cols) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= rows) cur_row = 0;
    end
  endtask

  // input beat taken at the last rising edge
  always @(posedge clk) begin
    in_fire <= in_bus.valid && in_bus.ready;
  end

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_fire) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 300) : 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pixel_t px;
        px = pixel_q.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.range_value <= px.range_value;
        in_bus.frame_start <= px.frame_start;
        burst_left--;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches on a timer, one long hold-off
  always @(negedge clk) begin
    if (mode_timer == 0) begin
      mode_timer = 256;
      stall_mode = $urandom_range(0, 2);
    end
    mode_timer--;
    if (!hold_done && pixels_in >= 400) begin
      hold_done = 1;
      hold_left = 4000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= $urandom_range(0, 1);
        default: out_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      pixel_t px;
      px.range_value = in_bus.range_value;
      px.frame_start = in_bus.frame_start;
      predict_normal(px);
      pixels_in++;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      normals_out++;
      if (normal_q.size() == 0) begin
        $error("normal beat with none expected at row %0d col %0d",
               out_bus.normal_row, out_bus.normal_col);
        errors++;
      end else begin
        normal_t n;
        n = normal_q.pop_front();
        if (out_bus.normal_x !== n.nx) begin
          $error("normal_x exp %h got %h", n.nx, out_bus.normal_x); errors++;
        end
        if (out_bus.normal_y !== n.ny) begin
          $error("normal_y exp %h got %h", n.ny, out_bus.normal_y); errors++;
        end
        if (out_bus.normal_z !== n.nz) begin
          $error("normal_z exp %h got %h", n.nz, out_bus.normal_z); errors++;
        end
        if (out_bus.normal_row !== n.row) begin
          $error("normal_row exp %0d got %0d", n.row, out_bus.normal_row); errors++;
        end
        if (out_bus.normal_col !== n.col) begin
          $error("normal_col exp %0d got %0d", n.col, out_bus.normal_col); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_bus.valid || normal_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic set_image(cfg_t c);
    wait_idle();
    reg_write(REG_COLS, 32'(c.cols));
    reg_write(REG_ROWS, 32'(c.rows));
    reg_write(REG_COL_STEP, 32'(c.col_step));
    reg_write(REG_LINE_STEP, 32'(c.line_step));
    reg_write(REG_SLANT_STEP, 32'(c.slant_step));
    reg_write(REG_STANDOFF, 32'(c.standoff));
    img_cfg = c;
    phases++;
  endtask

  // first beat resyncs unless told not to; noise_pct gives stray frame starts
  task automatic queue_pixels(int count, bit resync, int noise_pct);
    pixel_t px;
    for (int i = 0; i < count; i++) begin
      px.range_value = 8'($urandom);
      px.frame_start = (i == 0) ? resync : ($urandom_range(0, 99) < noise_pct);
      pixel_q.push_back(px);
    end
  endtask

  function automatic cfg_t make_cfg(int cols, int rows, int cstep, int lstep,
                                    int slant, int soff);
    cfg_t c;
    c.cols = 11'(cols);
    c.rows = 11'(rows);
    c.col_step = 24'(cstep);
    c.line_step = 24'(lstep);
    c.slant_step = 16'(slant);
    c.standoff = 8'(soff);
    return c;
  endfunction

  initial begin
    pixel_t px;
    cfg_t c;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_bus.valid = 1'b0; in_bus.range_value = '0; in_bus.frame_start = 1'b0;
    out_bus.ready = 1'b0;
    errors = 0; pixels_in = 0; normals_out = 0; phases = 0;
    burst_left = 0; gap_left = 0; hold_left = 0; hold_done = 0;
    stall_mode = 0; mode_timer = 0; idle_cycles = 0;
    cur_row = 0; cur_col = 0;
    foreach (pt_x[i]) begin
      pt_x[i] = 0; pt_y[i] = 0; pt_z[i] = 0;
    end
    img_cfg = make_cfg(128, 128, 137258, 137169, 715, 10);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes on a small image, normals start on line three
    set_image(make_cfg(8, 4, 137258, 137169, 715, 0));
    for (int i = 0; i < 25; i++) begin
      px.range_value = (i % 3 == 0) ? 8'd0 : ((i % 3 == 1) ? 8'd255 : 8'($urandom));
      px.frame_start = (i == 0);
      pixel_q.push_back(px);
    end
    // angle saturation with every step at full scale
    set_image(make_cfg(8, 8, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 255));
    queue_pixels(80, 1, 0);
    // zero steps
    set_image(make_cfg(9, 8, 0, 0, 0, 0));
    queue_pixels(60, 1, 0);
    // sizes clamped at both ends and too narrow for any normal
    set_image(make_cfg(0, 0, 137258, 137169, 715, 10));
    queue_pixels(10, 1, 0);
    set_image(make_cfg(2047, 2047, 137258, 137169, 715, 10));
    queue_pixels(20, 1, 0);
    set_image(make_cfg(1024, 1024, 137258, 137169, 715, 10));
    queue_pixels(20, 1, 0);
    set_image(make_cfg(3, 8, 137258, 137169, 715, 10));
    queue_pixels(30, 1, 0);
    // lower the width mid frame so the position lands past the new line end
    set_image(make_cfg(16, 8, 200000, 150000, 1000, 40));
    queue_pixels(16 * 5 + 12, 1, 0);
    c = img_cfg;
    c.cols = 11'd8;
    set_image(c);
    queue_pixels(70, 0, 0);

    while (pixels_in + pixel_q.size() < 1900) begin
      c = make_cfg($urandom_range(8, 20), $urandom_range(6, 12),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                               : $urandom_range(0, 400000),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                               : $urandom_range(0, 400000),
                   $urandom_range(0, 65535), $urandom_range(0, 255));
      set_image(c);
      queue_pixels($urandom_range(40, 200), 1, 2);
    end

    wait_idle();
    $display("run covered %0d pixels and %0d normals over %0d image settings",
             pixels_in, normals_out, phases);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rins_pkg.sv
rtl/rins_if.sv
rtl/rins_regs.sv
rtl/rins_ctrl.sv
rtl/rins_dp.sv
rtl/range_image_surface_normal.sv
dv/tb_range_image_surface_normal.sv
